@@ hdl/clwf_pkg.sv @@
// shared types, constants and key helpers for the cursor list block
package clwf_pkg;

    localparam int SLOTS_DEF  = 16;
    localparam int TEXT_CHARS = 8;

    localparam int ID_W   = 31;
    localparam int TEXT_W = 64;
    localparam int SEX_W  = 8;
    localparam int SLOT_W = 4;

    localparam logic [SEX_W-1:0] SPACE_CODE = 8'd32;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef struct packed {
        logic [TEXT_W-1:0] prog;
        logic [SEX_W-1:0]  sex;
        logic [TEXT_W-1:0] name;
        logic [ID_W-1:0]   id;
    } t_rec;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
    } t_res;

    localparam t_rec REC_EMPTY = '{prog: '0, sex: SPACE_CODE, name: '0, id: '0};

    // cut to TEXT_CHARS bytes, everything after the first zero byte is zero
    function automatic logic [TEXT_W-1:0] text_norm(input logic [TEXT_W-1:0] key);
        logic [TEXT_W-1:0] r;
        logic              live;
        r    = '0;
        live = 1'b1;
        for (int k = 0; k < 8; k++) begin
            if (k >= TEXT_CHARS || key[8*k +: 8] == 8'h00) begin
                live = 1'b0;
            end
            if (live) begin
                r[8*k +: 8] = key[8*k +: 8];
            end
        end
        return r;
    endfunction

endpackage

@@ hdl/clwf_ram.sv @@
// generic single write port ram with registered read
module clwf_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/clwf_ctrl.sv @@
// sequencer: clearing pass, insert, list walk with name compare, unlink and free
module clwf_ctrl import clwf_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF,
    parameter int AW    = $clog2(SLOTS),
    parameter int LW    = $clog2(SLOTS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // request side
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  logic          i_req_cmd,
    input  t_rec          i_req_rec,
    // result side
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output t_res          o_res_hdr,
    output t_rec          o_res_rec,
    // record and link memories, one shared read address
    output logic [AW-1:0] o_raddr,
    output logic          o_rec_we,
    output logic [AW-1:0] o_rec_waddr,
    output t_rec          o_rec_wdata,
    input  t_rec          i_rec_rdata,
    output logic          o_lnk_we,
    output logic [AW-1:0] o_lnk_waddr,
    output logic [LW-1:0] o_lnk_wdata,
    input  logic [LW-1:0] i_lnk_rdata
);

    localparam logic [LW-1:0] NULL_LINK = LW'(SLOTS);
    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_INS   = 6'b000100,
        S_WALK  = 6'b001000,
        S_FREE  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [LW-1:0] r_free_head, n_free_head;
    logic [LW-1:0] r_list_head, n_list_head;
    logic [LW-1:0] r_cur, n_cur;
    logic [LW-1:0] r_prev, n_prev;
    logic [LW-1:0] r_steps, n_steps;
    t_rec          r_req, n_req;
    t_res          r_hdr, n_hdr;
    t_rec          r_rec, n_rec;

    logic          cur_ok;
    logic          lnk_ok;
    logic [LW-1:0] nxt;

    assign cur_ok = (r_cur < NULL_LINK);
    assign lnk_ok = (i_lnk_rdata < NULL_LINK);
    assign nxt    = lnk_ok ? i_lnk_rdata : NULL_LINK;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_free_head = r_free_head;
        n_list_head = r_list_head;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_steps     = r_steps;
        n_req       = r_req;
        n_hdr       = r_hdr;
        n_rec       = r_rec;
        o_raddr     = '0;
        o_rec_we    = 1'b0;
        o_rec_waddr = r_cur[AW-1:0];
        o_rec_wdata = REC_EMPTY;
        o_lnk_we    = 1'b0;
        o_lnk_waddr = r_cur[AW-1:0];
        o_lnk_wdata = r_free_head;
        case (r_state)
            S_CLEAR: begin
                o_rec_we    = 1'b1;
                o_rec_waddr = r_clr;
                o_lnk_we    = 1'b1;
                o_lnk_waddr = r_clr;
                o_lnk_wdata = (r_clr == '0) ? NULL_LINK : LW'(r_clr) - LW'(1);
                n_clr       = r_clr + AW'(1);
                if (r_clr == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req = i_req_rec;
                    if (i_req_cmd == CMD_INSERT) begin
                        if (r_free_head >= NULL_LINK) begin
                            n_hdr   = '{status: ST_FULL, slot: '0};
                            n_rec   = REC_EMPTY;
                            n_state = S_OUT;
                        end else begin
                            o_raddr = r_free_head[AW-1:0];
                            n_state = S_INS;
                        end
                    end else begin
                        n_cur   = r_list_head;
                        n_prev  = NULL_LINK;
                        n_steps = '0;
                        o_raddr = (r_list_head < NULL_LINK) ? r_list_head[AW-1:0] : '0;
                        n_state = S_WALK;
                    end
                end
            end
            S_INS: begin
                o_rec_we    = 1'b1;
                o_rec_waddr = r_free_head[AW-1:0];
                o_rec_wdata = r_req;
                o_lnk_we    = 1'b1;
                o_lnk_waddr = r_free_head[AW-1:0];
                o_lnk_wdata = r_list_head;
                n_list_head = r_free_head;
                n_free_head = nxt;
                n_hdr       = '{status: ST_DONE, slot: SLOT_W'(r_free_head)};
                n_rec       = REC_EMPTY;
                n_state     = S_OUT;
            end
            S_WALK: begin
                if (!cur_ok || r_steps >= NULL_LINK) begin
                    n_hdr   = '{status: ST_NOT_FOUND, slot: '0};
                    n_rec   = REC_EMPTY;
                    n_state = S_OUT;
                end else if (i_rec_rdata.name == r_req.name) begin
                    // unlink the match and clear its record
                    if (r_prev < NULL_LINK) begin
                        o_lnk_we    = 1'b1;
                        o_lnk_waddr = r_prev[AW-1:0];
                        o_lnk_wdata = nxt;
                    end else begin
                        n_list_head = nxt;
                    end
                    o_rec_we    = 1'b1;
                    o_rec_waddr = r_cur[AW-1:0];
                    o_rec_wdata = REC_EMPTY;
                    n_hdr       = '{status: ST_DONE, slot: SLOT_W'(r_cur)};
                    n_rec       = i_rec_rdata;
                    n_state     = S_FREE;
                end else begin
                    n_prev  = r_cur;
                    n_cur   = i_lnk_rdata;
                    n_steps = r_steps + LW'(1);
                    o_raddr = lnk_ok ? i_lnk_rdata[AW-1:0] : '0;
                end
            end
            S_FREE: begin
                o_lnk_we    = 1'b1;
                o_lnk_waddr = r_cur[AW-1:0];
                o_lnk_wdata = r_free_head;
                n_free_head = r_cur;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_free_head <= LW'(SLOTS - 1);
            r_list_head <= NULL_LINK;
            r_steps     <= '0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_free_head <= n_free_head;
            r_list_head <= n_list_head;
            r_steps     <= n_steps;
        end
        r_cur  <= n_cur;
        r_prev <= n_prev;
        r_req  <= n_req;
        r_hdr  <= n_hdr;
        r_rec  <= n_rec;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_OUT);
    assign o_res_hdr   = r_hdr;
    assign o_res_rec   = r_rec;

    a_onehot_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

    a_heads_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free_head < NULL_LINK && r_list_head < NULL_LINK) |->
        (r_free_head != r_list_head))
        else $error("free chain and record list share a head slot");

    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps <= NULL_LINK)
        else $error("list walk ran past the slot count");

    a_free_after_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FREE) |-> $past(r_state == S_WALK))
        else $error("free step without a matching walk");

    a_free_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FREE) |=> (r_free_head == $past(r_cur)))
        else $error("freed slot not pushed on the free chain");

endmodule

@@ hdl/cursor_list_with_free_list.sv @@
// top level: cursor based record list with free list over a fixed slot store
//
// usage
//   s_axis carries one request: tuser selects insert at front (0) or remove
//   first record by name (1); tdata carries the record fields.
//   m_axis carries one result per request: tuser is the status (done, store
//   full, name not found), tdata the slot index and the removed record.
//   name and program keys are cut to TEXT_CHARS bytes and end at the first
//   zero byte, both when stored and when compared.
// request flow
//   one request at a time; s_axis_tready is high only while the sequencer idles
//   insert: an insert step writes the slot, then the result is offered; a full
//   store offers it straight from idle. remove: the walk reads one list entry
//   per cycle through the registered memory read; a match passes a free step
//   before the result, a miss ends at the list end or after SLOTS entries
// reset
//   after i_rst_n is released a clearing pass writes the empty record and the
//   initial free chain into every slot; no request is taken meanwhile
// stall
//   the result sits in an output register; a new request is taken while it
//   waits, and the sequencer holds the next result until the register frees
module cursor_list_with_free_list import clwf_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // stud_id[30:0], name_key[94:31], sex_code[102:95], program_key[166:103], zero pad
    input  logic [167:0] s_axis_tdata,
    // command[0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // slot_index[3:0], out_id[34:4], out_name[98:35], out_sex[106:99],
    // out_program[170:107], zero pad
    output logic [175:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]   m_axis_tuser
);

    localparam int AW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);

    // request with keys brought into stored form
    t_rec          req_rec;

    // sequencer result side
    logic          res_valid;
    logic          res_ready;
    t_res          res_hdr;
    t_rec          res_rec;

    // memory ports
    logic [AW-1:0] raddr;
    logic          rec_we;
    logic [AW-1:0] rec_waddr;
    t_rec          rec_wdata;
    t_rec          rec_rdata;
    logic          lnk_we;
    logic [AW-1:0] lnk_waddr;
    logic [LW-1:0] lnk_wdata;
    logic [LW-1:0] lnk_rdata;

    // output register
    logic          r_m_valid;
    t_res          r_m_hdr;
    t_rec          r_m_rec;

    assign req_rec.id   = s_axis_tdata[30:0];
    assign req_rec.name = text_norm(s_axis_tdata[94:31]);
    assign req_rec.sex  = s_axis_tdata[102:95];
    assign req_rec.prog = text_norm(s_axis_tdata[166:103]);

    clwf_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req_cmd   (s_axis_tuser),
        .i_req_rec   (req_rec),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res_hdr   (res_hdr),
        .o_res_rec   (res_rec),
        .o_raddr     (raddr),
        .o_rec_we    (rec_we),
        .o_rec_waddr (rec_waddr),
        .o_rec_wdata (rec_wdata),
        .i_rec_rdata (rec_rdata),
        .o_lnk_we    (lnk_we),
        .o_lnk_waddr (lnk_waddr),
        .o_lnk_wdata (lnk_wdata),
        .i_lnk_rdata (lnk_rdata)
    );

    // record fields of every slot
    clwf_ram #(
        .WIDTH ($bits(t_rec)),
        .DEPTH (SLOTS)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_waddr (rec_waddr),
        .i_wdata (rec_wdata),
        .i_raddr (raddr),
        .o_rdata (rec_rdata)
    );

    // next-slot links for both chains, null is the code SLOTS
    clwf_ram #(
        .WIDTH (LW),
        .DEPTH (SLOTS)
    ) u_lnk_ram (
        .i_clk   (i_clk),
        .i_we    (lnk_we),
        .i_waddr (lnk_waddr),
        .i_wdata (lnk_wdata),
        .i_raddr (raddr),
        .o_rdata (lnk_rdata)
    );

    // output register takes a result when empty or being drained
    assign res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_m_hdr <= res_hdr;
            r_m_rec <= res_rec;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_hdr.status;
    assign m_axis_tdata  = {5'b0, r_m_rec.prog, r_m_rec.sex, r_m_rec.name,
                            r_m_rec.id, r_m_hdr.slot};

endmodule
